FILE: rtl/pat_pkg.sv
`default_nettype none

package pat_pkg;

	localparam int KIND_W      = 2;
	localparam int OFFSET_W    = 24;
	localparam int ANGLE_W     = 16;
	localparam int FACTOR_W    = 16;
	localparam int INDEX_W     = 2;
	localparam int TRIG_W      = 32;
	localparam int Z_W         = 26;
	localparam int ANG_RED_W   = 17;
	localparam int TABLE_IDX_W = 5;
	localparam int PC_W        = 5;

	localparam int ANGLE_SCALE_SH = 10;
	localparam int Q8_SHIFT       = 8;
	localparam int Q30_SHIFT      = 30;
	localparam int ROUND_Q8       = 1 << (Q8_SHIFT - 1);
	localparam int ROUND_Q30      = 1 << (Q30_SHIFT - 1);
	localparam int RESET_HALF     = 25600;

	localparam logic signed [ANG_RED_W-1:0] FULL_TURN    = 17'sd23040;
	localparam logic signed [ANG_RED_W-1:0] HALF_TURN    = 17'sd11520;
	localparam logic signed [ANG_RED_W-1:0] QUARTER_TURN = 17'sd5760;
	localparam logic signed [TRIG_W-1:0]    CORDIC_GAIN  = 32'sd652032874;

	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_IDLE      = 5'd0;
	localparam pc_t PC_TRANSLATE = 5'd1;
	localparam pc_t PC_SCALE     = 5'd6;
	localparam pc_t PC_ROTATE    = 5'd12;
	localparam pc_t PC_ROT_LOOP  = 5'd15;

	typedef enum logic [KIND_W-1:0] {
		KIND_TRANSLATE = 2'd0,
		KIND_ROTATE    = 2'd1,
		KIND_SCALE     = 2'd2,
		KIND_NONE      = 2'd3
	} kind_t;

	typedef enum logic {MA_X, MA_Y} mul_a_t;
	typedef enum logic [1:0] {MB_COS, MB_SIN, MB_FX, MB_FY} mul_b_t;
	typedef enum logic [2:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_TX, ACC_TY} acc_op_t;
	typedef enum logic [1:0] {SH_0, SH_8, SH_30} rnd_sh_t;
	typedef enum logic [1:0] {SD_NONE, SD_X, SD_Y} sat_dst_t;
	typedef enum logic [2:0] {SQ_IDLE, SQ_NEXT, SQ_PREP, SQ_ITER, SQ_FIN, SQ_EMIT} seq_op_t;

	typedef struct packed {
		seq_op_t  seq;
		logic     mul_en;
		mul_a_t   mul_a;
		mul_b_t   mul_b;
		acc_op_t  acc_op;
		logic     rnd_en;
		rnd_sh_t  rnd_sh;
		sat_dst_t sat_dst;
		pc_t      target;
	} ctrl_t;

	localparam ctrl_t CTRL_NOP = '{
		seq:     SQ_NEXT,
		mul_en:  1'b0,
		mul_a:   MA_X,
		mul_b:   MB_COS,
		acc_op:  ACC_HOLD,
		rnd_en:  1'b0,
		rnd_sh:  SH_0,
		sat_dst: SD_NONE,
		target:  PC_IDLE
	};

	// atan(2^-i) in degrees, Q.16
	function automatic logic signed [Z_W-1:0] atan_q16(input logic [TABLE_IDX_W-1:0] idx);
		case (idx)
			5'd0:    return 26'sd2949120;
			5'd1:    return 26'sd1740967;
			5'd2:    return 26'sd919879;
			5'd3:    return 26'sd466945;
			5'd4:    return 26'sd234379;
			5'd5:    return 26'sd117304;
			5'd6:    return 26'sd58666;
			5'd7:    return 26'sd29335;
			5'd8:    return 26'sd14668;
			5'd9:    return 26'sd7334;
			5'd10:   return 26'sd3667;
			5'd11:   return 26'sd1833;
			5'd12:   return 26'sd917;
			5'd13:   return 26'sd458;
			5'd14:   return 26'sd229;
			5'd15:   return 26'sd115;
			5'd16:   return 26'sd57;
			5'd17:   return 26'sd29;
			5'd18:   return 26'sd14;
			5'd19:   return 26'sd7;
			5'd20:   return 26'sd4;
			5'd21:   return 26'sd2;
			5'd22:   return 26'sd1;
			default: return 26'sd0;
		endcase
	endfunction

	// square at plus or minus 100, pattern repeats every four corners
	function automatic logic signed [31:0] reset_x(input logic [1:0] idx);
		case (idx)
			2'd1, 2'd2: return 32'(RESET_HALF);
			default:    return -32'(RESET_HALF);
		endcase
	endfunction

	function automatic logic signed [31:0] reset_y(input logic [1:0] idx);
		case (idx)
			2'd2, 2'd3: return 32'(RESET_HALF);
			default:    return -32'(RESET_HALF);
		endcase
	endfunction

endpackage

`default_nettype wire

FILE: rtl/pat_stream_if.sv
`default_nettype none

interface pat_cmd_if import pat_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [KIND_W-1:0]          kind;
	logic signed [OFFSET_W-1:0] offset_x;
	logic signed [OFFSET_W-1:0] offset_y;
	logic signed [ANGLE_W-1:0]  angle;
	logic signed [FACTOR_W-1:0] factor_x;
	logic signed [FACTOR_W-1:0] factor_y;

	modport source (
		output valid, kind, offset_x, offset_y, angle, factor_x, factor_y,
		input  ready
	);
	modport sink (
		input  valid, kind, offset_x, offset_y, angle, factor_x, factor_y,
		output ready
	);
endinterface

interface pat_corner_if import pat_pkg::*; #(parameter int COORD_WIDTH = 24);
	logic                          valid;
	logic                          ready;
	logic [INDEX_W-1:0]            corner_index;
	logic signed [COORD_WIDTH-1:0] corner_x_out;
	logic signed [COORD_WIDTH-1:0] corner_y_out;
	logic                          last;

	modport source (
		output valid, corner_index, corner_x_out, corner_y_out, last,
		input  ready
	);
	modport sink (
		input  valid, corner_index, corner_x_out, corner_y_out, last,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/pat_seq.sv
`default_nettype none

module pat_seq import pat_pkg::*; #(
	parameter int CORNER_COUNT = 4,
	parameter int CORDIC_STEPS = 16,
	localparam int CI_W = $clog2(CORNER_COUNT),
	localparam int IT_W = $clog2(CORDIC_STEPS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic              out_busy,
	output ctrl_t                  ctrl,
	output logic [CI_W-1:0]        ci,
	output logic [IT_W-1:0]        it,
	output logic                   idle,
	output logic                   emit
);

	pc_t             pc_q;
	logic [CI_W-1:0] ci_q;
	logic [IT_W-1:0] it_q;

	function automatic ctrl_t ucode(input pc_t addr);
		ctrl_t w;
		w = CTRL_NOP;
		case (addr)
			// translate, one corner
			PC_TRANSLATE: begin
				w.acc_op = ACC_TX;
			end
			PC_TRANSLATE + PC_W'(1): begin
				w.rnd_en = 1'b1; w.rnd_sh = SH_0; w.acc_op = ACC_TY;
			end
			PC_TRANSLATE + PC_W'(2): begin
				w.sat_dst = SD_X; w.rnd_en = 1'b1; w.rnd_sh = SH_0;
			end
			PC_TRANSLATE + PC_W'(3): begin
				w.sat_dst = SD_Y;
			end
			PC_TRANSLATE + PC_W'(4): begin
				w.seq = SQ_EMIT; w.target = PC_TRANSLATE;
			end
			// scale, one corner
			PC_SCALE: begin
				w.mul_en = 1'b1; w.mul_a = MA_X; w.mul_b = MB_FX;
			end
			PC_SCALE + PC_W'(1): begin
				w.acc_op = ACC_LOAD; w.mul_en = 1'b1; w.mul_a = MA_Y; w.mul_b = MB_FY;
			end
			PC_SCALE + PC_W'(2): begin
				w.rnd_en = 1'b1; w.rnd_sh = SH_8; w.acc_op = ACC_LOAD;
			end
			PC_SCALE + PC_W'(3): begin
				w.sat_dst = SD_X; w.rnd_en = 1'b1; w.rnd_sh = SH_8;
			end
			PC_SCALE + PC_W'(4): begin
				w.sat_dst = SD_Y;
			end
			PC_SCALE + PC_W'(5): begin
				w.seq = SQ_EMIT; w.target = PC_SCALE;
			end
			// rotate: cordic, then one corner per loop
			PC_ROTATE: begin
				w.seq = SQ_PREP;
			end
			PC_ROTATE + PC_W'(1): begin
				w.seq = SQ_ITER;
			end
			PC_ROTATE + PC_W'(2): begin
				w.seq = SQ_FIN;
			end
			PC_ROT_LOOP: begin
				w.mul_en = 1'b1; w.mul_a = MA_X; w.mul_b = MB_COS;
			end
			PC_ROT_LOOP + PC_W'(1): begin
				w.acc_op = ACC_LOAD; w.mul_en = 1'b1; w.mul_a = MA_Y; w.mul_b = MB_SIN;
			end
			PC_ROT_LOOP + PC_W'(2): begin
				w.acc_op = ACC_SUB; w.mul_en = 1'b1; w.mul_a = MA_X; w.mul_b = MB_SIN;
			end
			PC_ROT_LOOP + PC_W'(3): begin
				w.rnd_en = 1'b1; w.rnd_sh = SH_30; w.acc_op = ACC_LOAD;
				w.mul_en = 1'b1; w.mul_a = MA_Y; w.mul_b = MB_COS;
			end
			PC_ROT_LOOP + PC_W'(4): begin
				w.sat_dst = SD_X; w.acc_op = ACC_ADD;
			end
			PC_ROT_LOOP + PC_W'(5): begin
				w.rnd_en = 1'b1; w.rnd_sh = SH_30;
			end
			PC_ROT_LOOP + PC_W'(6): begin
				w.sat_dst = SD_Y;
			end
			PC_ROT_LOOP + PC_W'(7): begin
				w.seq = SQ_EMIT; w.target = PC_ROT_LOOP;
			end
			default: begin
				w.seq = SQ_IDLE;
			end
		endcase
		return w;
	endfunction

	assign ctrl = ucode(pc_q);
	assign ci   = ci_q;
	assign it   = it_q;
	assign idle = (ctrl.seq == SQ_IDLE);
	assign emit = (ctrl.seq == SQ_EMIT) && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
			ci_q <= '0;
			it_q <= '0;
		end else begin
			case (ctrl.seq)
				SQ_IDLE: begin
					if (start) begin
						case (kind_t'(kind))
							KIND_TRANSLATE: pc_q <= PC_TRANSLATE;
							KIND_ROTATE:    pc_q <= PC_ROTATE;
							KIND_SCALE:     pc_q <= PC_SCALE;
							default:        pc_q <= PC_IDLE;
						endcase
					end
				end
				SQ_ITER: begin
					if (it_q == IT_W'(CORDIC_STEPS - 1)) begin
						it_q <= '0;
						pc_q <= pc_q + 1'b1;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				SQ_EMIT: begin
					if (!out_busy) begin
						if (ci_q == CI_W'(CORNER_COUNT - 1)) begin
							ci_q <= '0;
							pc_q <= PC_IDLE;
						end else begin
							ci_q <= ci_q + 1'b1;
							pc_q <= ctrl.target;
						end
					end
				end
				default: begin
					pc_q <= pc_q + 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/polygon_affine_transform.sv
// Keeps the corners of a polygon (reset: square at plus or minus 100.0, signed Q16.8) and
// applies one translate, rotate or scale command item to every corner, then emits the
// updated corners in order with last on the final one. A small microcode program drives
// one shared 24x32 multiplier and accumulator. A rotate first runs CORDIC_STEPS cordic
// iterations, and a corner held back at the output stalls the program. Kind 3 is
// accepted and does nothing. A new command is taken in the cycle after the previous one
// has loaded its last corner into the output register.
`default_nettype none

module polygon_affine_transform import pat_pkg::*; #(
	parameter int CORNER_COUNT = 4,
	parameter int COORD_WIDTH  = 24,
	parameter int CORDIC_STEPS = 16
) (
	input wire logic     clk,
	input wire logic     arst_n,
	pat_cmd_if.sink      cmd,
	pat_corner_if.source corner
);

	localparam int CI_W   = $clog2(CORNER_COUNT);
	localparam int IT_W   = $clog2(CORDIC_STEPS);
	localparam int PROD_W = COORD_WIDTH + TRIG_W;
	localparam int ACC_W  = PROD_W + 1;

	localparam logic signed [ACC_W-1:0] COORD_MAX =
		{{(ACC_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] COORD_MIN = ~COORD_MAX;

	ctrl_t           ctrl;
	logic [CI_W-1:0] ci;
	logic [IT_W-1:0] it;
	logic            idle;
	logic            emit;
	logic            accept;
	logic            out_busy;

	logic signed [OFFSET_W-1:0] off_x_q, off_y_q;
	logic signed [ANGLE_W-1:0]  angle_q;
	logic signed [FACTOR_W-1:0] fac_x_q, fac_y_q;

	logic signed [COORD_WIDTH-1:0] corner_x_q [CORNER_COUNT];
	logic signed [COORD_WIDTH-1:0] corner_y_q [CORNER_COUNT];
	logic signed [COORD_WIDTH-1:0] cur_x, cur_y;

	logic signed [TRIG_W-1:0] cx_q, cy_q, dx, dy;
	logic signed [Z_W-1:0]    cz_q;
	logic                     neg_q;

	logic signed [ANG_RED_W-1:0] ang_a, ang_r, ang_h, ang_f;
	logic                        ang_neg;

	logic signed [COORD_WIDTH-1:0] mul_a;
	logic signed [TRIG_W-1:0]      mul_b;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [ACC_W-1:0]       acc_q, rnd_q, rnd_val;
	logic signed [COORD_WIDTH-1:0] sat_val, nx_q, ny_q;

	logic                          out_valid_q;
	logic [INDEX_W-1:0]            out_index_q;
	logic signed [COORD_WIDTH-1:0] out_x_q, out_y_q;
	logic                          out_last_q;

	pat_seq #(
		.CORNER_COUNT(CORNER_COUNT),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.kind     (cmd.kind),
		.out_busy (out_busy),
		.ctrl     (ctrl),
		.ci       (ci),
		.it       (it),
		.idle     (idle),
		.emit     (emit)
	);

	assign cmd.ready = idle;
	assign accept    = cmd.valid && idle;
	assign out_busy  = out_valid_q && !corner.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			off_x_q <= cmd.offset_x;
			off_y_q <= cmd.offset_y;
			angle_q <= cmd.angle;
			fac_x_q <= cmd.factor_x;
			fac_y_q <= cmd.factor_y;
		end
	end

	// corner store
	assign cur_x = corner_x_q[ci];
	assign cur_y = corner_y_q[ci];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CORNER_COUNT; i++) begin
				corner_x_q[i] <= COORD_WIDTH'(reset_x(2'(i)));
				corner_y_q[i] <= COORD_WIDTH'(reset_y(2'(i)));
			end
		end else if (emit) begin
			corner_x_q[ci] <= nx_q;
			corner_y_q[ci] <= ny_q;
		end
	end

	// angle reduction: wrap to a full turn, then fold into plus or minus a quarter turn
	always_comb begin
		ang_a = ANG_RED_W'(angle_q);
		if (ang_a >= FULL_TURN) begin
			ang_r = ang_a - FULL_TURN;
		end else if (ang_a >= 0) begin
			ang_r = ang_a;
		end else if (ang_a >= -FULL_TURN) begin
			ang_r = ang_a + FULL_TURN;
		end else begin
			ang_r = ang_a + FULL_TURN + FULL_TURN;
		end
		ang_h   = (ang_r > HALF_TURN) ? ang_r - FULL_TURN : ang_r;
		ang_neg = 1'b0;
		ang_f   = ang_h;
		if (ang_h > QUARTER_TURN) begin
			ang_f   = ang_h - HALF_TURN;
			ang_neg = 1'b1;
		end else if (ang_h < -QUARTER_TURN) begin
			ang_f   = ang_h + HALF_TURN;
			ang_neg = 1'b1;
		end
	end

	// cordic, one iteration per cycle
	assign dx = cy_q >>> it;
	assign dy = cx_q >>> it;

	always_ff @(posedge clk) begin
		case (ctrl.seq)
			SQ_PREP: begin
				cx_q  <= CORDIC_GAIN;
				cy_q  <= '0;
				cz_q  <= Z_W'(ang_f) <<< ANGLE_SCALE_SH;
				neg_q <= ang_neg;
			end
			SQ_ITER: begin
				if (!cz_q[Z_W-1]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - atan_q16(TABLE_IDX_W'(it));
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + atan_q16(TABLE_IDX_W'(it));
				end
			end
			SQ_FIN: begin
				if (neg_q) begin
					cx_q <= -cx_q;
					cy_q <= -cy_q;
				end
			end
			default: begin
			end
		endcase
	end

	// shared multiplier and accumulator
	assign mul_a = (ctrl.mul_a == MA_X) ? cur_x : cur_y;

	always_comb begin
		case (ctrl.mul_b)
			MB_COS:  mul_b = cx_q;
			MB_SIN:  mul_b = cy_q;
			MB_FX:   mul_b = TRIG_W'(fac_x_q);
			MB_FY:   mul_b = TRIG_W'(fac_y_q);
			default: mul_b = cx_q;
		endcase
	end

	always_comb begin
		case (ctrl.rnd_sh)
			SH_8:    rnd_val = (acc_q + ACC_W'(ROUND_Q8)) >>> Q8_SHIFT;
			SH_30:   rnd_val = (acc_q + ACC_W'(ROUND_Q30)) >>> Q30_SHIFT;
			default: rnd_val = acc_q;
		endcase
	end

	always_comb begin
		if (rnd_q > COORD_MAX) begin
			sat_val = COORD_MAX[COORD_WIDTH-1:0];
		end else if (rnd_q < COORD_MIN) begin
			sat_val = COORD_MIN[COORD_WIDTH-1:0];
		end else begin
			sat_val = rnd_q[COORD_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		case (ctrl.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod_q);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
			ACC_SUB:  acc_q <= acc_q - ACC_W'(prod_q);
			ACC_TX:   acc_q <= ACC_W'(cur_x) + ACC_W'(off_x_q);
			ACC_TY:   acc_q <= ACC_W'(cur_y) + ACC_W'(off_y_q);
			default:  acc_q <= acc_q;
		endcase
		if (ctrl.rnd_en) begin
			rnd_q <= rnd_val;
		end
		case (ctrl.sat_dst)
			SD_X:    nx_q <= sat_val;
			SD_Y:    ny_q <= sat_val;
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (corner.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_index_q <= ci[INDEX_W-1:0];
			out_x_q     <= nx_q;
			out_y_q     <= ny_q;
			out_last_q  <= (ci == CI_W'(CORNER_COUNT - 1));
		end
	end

	assign corner.valid        = out_valid_q;
	assign corner.corner_index = out_index_q;
	assign corner.corner_x_out = out_x_q;
	assign corner.corner_y_out = out_y_q;
	assign corner.last         = out_last_q;

	a_none_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.kind == KIND_NONE) |=> cmd.ready)
		else $error("unused kind started a program");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && ci == CI_W'(CORNER_COUNT - 1)) |=> cmd.ready)
		else $error("sequencer not idle after last corner");

	a_idle_corner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> ci == '0)
		else $error("corner counter not cleared while idle");

	a_emit_shows_item: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> corner.valid)
		else $error("emitted corner not presented");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.seq == SQ_ITER) |-> it <= IT_W'(CORDIC_STEPS - 1))
		else $error("cordic step counter out of range");

endmodule

`default_nettype wire
